/* src/pas_pkg.sv */
`default_nettype none

package pas_pkg;

    localparam int SLOTS      = 16;
    localparam int ID_BITS    = 8;
    localparam int PRIO_BITS  = 6;
    localparam int IDX_BITS   = $clog2(SLOTS);
    localparam int CNT_BITS   = $clog2(SLOTS + 1);
    localparam int ENTRY_BITS = ID_BITS + PRIO_BITS;

    localparam logic signed [PRIO_BITS-1:0] PRIO_MIN  = -6'sd20;
    localparam logic signed [PRIO_BITS-1:0] PRIO_MAX  = 6'sd20;
    localparam logic signed [PRIO_BITS-1:0] AGE_RESET = -6'sd1;

    localparam logic FUNC_INSERT   = 1'b0;
    localparam logic FUNC_DISPATCH = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

`default_nettype wire

/* src/pas_ram.sv */
`default_nettype none

module pas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* src/priority_aging_scheduler_unit.sv */
`default_nettype none

// Channel   Direction  Handshake               Beat
// in        in         in_valid / in_ready     func, task_id, start_prio
// out       out        out_valid / out_ready   status, chosen_id, chosen_prio, ready_count
// cfg       in         cfg_valid / cfg_ready   aging_amount
//
// Insert, full insert and empty dispatch: result registered in the cycle after the input beat.
// Dispatch over N entries makes two passes through the single read port of the slot
// memory, whose reads are registered: N reads to find the strongest, then N-1 reads
// to close the gap and age; a single entry skips the second pass.
// One item is in flight at a time; an input beat is taken whenever the block is idle
// and the output register is empty or being drained. Reset clears the fill count,
// control and result registers and sets the aging step; slot contents need no clearing.

module priority_aging_scheduler_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        func,
    input  wire logic [7:0]  task_id,
    input  wire logic signed [5:0] start_prio,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [1:0]  status,
    output logic      [7:0]  chosen_id,
    output logic signed [5:0] chosen_prio,
    output logic      [4:0]  ready_count,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic signed [5:0] aging_amount
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMPACT
    } state_t;

    state_t                                      state_reg;
    logic [pas_pkg::CNT_BITS-1:0]                fill_reg;
    logic signed [pas_pkg::PRIO_BITS-1:0]        step_reg;
    logic [pas_pkg::CNT_BITS-1:0]                ptr_reg;
    logic                                        rd_vld_reg;
    logic [pas_pkg::IDX_BITS-1:0]                rd_idx_reg;
    logic [pas_pkg::IDX_BITS-1:0]                best_idx_reg;
    logic signed [pas_pkg::PRIO_BITS-1:0]        best_prio_reg;
    logic [pas_pkg::ID_BITS-1:0]                 best_id_reg;

    logic                                        out_valid_reg;
    pas_pkg::status_t                            status_reg;
    logic [7:0]                                  chosen_id_reg;
    logic signed [5:0]                           chosen_prio_reg;
    logic [4:0]                                  ready_count_reg;

    logic                                        in_fire;
    logic                                        full;
    logic signed [pas_pkg::PRIO_BITS-1:0]        sat_prio;

    logic                                        ram_we;
    logic [pas_pkg::IDX_BITS-1:0]                ram_waddr;
    logic [pas_pkg::ENTRY_BITS-1:0]              ram_wdata;
    logic                                        ram_re;
    logic [pas_pkg::IDX_BITS-1:0]                ram_raddr;
    logic [pas_pkg::ENTRY_BITS-1:0]              ram_rdata;

    logic [pas_pkg::ID_BITS-1:0]                 rd_id;
    logic signed [pas_pkg::PRIO_BITS-1:0]        rd_prio;
    logic signed [pas_pkg::PRIO_BITS:0]          aged_wide;
    logic signed [pas_pkg::PRIO_BITS-1:0]        aged_prio;
    logic [pas_pkg::CNT_BITS-1:0]                fill_m1;
    logic [pas_pkg::CNT_BITS-1:0]                compact_src;
    logic                                        take;
    logic                                        scan_last;
    logic                                        compact_last;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign full      = (fill_reg == pas_pkg::CNT_BITS'(pas_pkg::SLOTS));
    assign fill_m1   = fill_reg - pas_pkg::CNT_BITS'(1);

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign chosen_id   = chosen_id_reg;
    assign chosen_prio = chosen_prio_reg;
    assign ready_count = ready_count_reg;

    always_comb
    begin
        if (start_prio < pas_pkg::PRIO_MIN)
        begin
            sat_prio = pas_pkg::PRIO_MIN;
        end
        else if (start_prio > pas_pkg::PRIO_MAX)
        begin
            sat_prio = pas_pkg::PRIO_MAX;
        end
        else
        begin
            sat_prio = start_prio;
        end
    end

    assign rd_id   = ram_rdata[pas_pkg::ENTRY_BITS-1:pas_pkg::PRIO_BITS];
    assign rd_prio = signed'(ram_rdata[pas_pkg::PRIO_BITS-1:0]);

    // aging only applies when the result stays inside the priority range
    assign aged_wide = {rd_prio[pas_pkg::PRIO_BITS-1], rd_prio}
                     + {step_reg[pas_pkg::PRIO_BITS-1], step_reg};
    assign aged_prio = (aged_wide >= 7'(pas_pkg::PRIO_MIN) && aged_wide <= 7'(pas_pkg::PRIO_MAX))
                     ? aged_wide[pas_pkg::PRIO_BITS-1:0] : rd_prio;

    assign take         = (rd_idx_reg == '0) || (rd_prio < best_prio_reg);
    assign scan_last    = rd_vld_reg && (rd_idx_reg == pas_pkg::IDX_BITS'(fill_m1));
    assign compact_last = rd_vld_reg
                       && (rd_idx_reg == pas_pkg::IDX_BITS'(fill_reg - pas_pkg::CNT_BITS'(2)));

    // entries past the removed one slide down by one
    assign compact_src = (ptr_reg < {1'b0, best_idx_reg}) ? ptr_reg
                                                          : ptr_reg + pas_pkg::CNT_BITS'(1);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = fill_reg[pas_pkg::IDX_BITS-1:0];
        ram_wdata = {pas_pkg::ID_BITS'(task_id), sat_prio};
        ram_re    = 1'b0;
        ram_raddr = ptr_reg[pas_pkg::IDX_BITS-1:0];
        case (state_reg)
            S_IDLE:
            begin
                ram_we = in_fire && (func == pas_pkg::FUNC_INSERT) && !full;
            end
            S_SCAN:
            begin
                ram_re = (ptr_reg < fill_reg);
            end
            S_COMPACT:
            begin
                ram_re    = (ptr_reg < fill_m1);
                ram_raddr = compact_src[pas_pkg::IDX_BITS-1:0];
                // write trails read, so it never overtakes an entry still to be read
                ram_we    = rd_vld_reg;
                ram_waddr = rd_idx_reg;
                ram_wdata = {rd_id, aged_prio};
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    pas_ram #(
        .WIDTH (pas_pkg::ENTRY_BITS),
        .DEPTH (pas_pkg::SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            fill_reg        <= '0;
            step_reg        <= pas_pkg::AGE_RESET;
            ptr_reg         <= '0;
            rd_vld_reg      <= 1'b0;
            rd_idx_reg      <= '0;
            best_idx_reg    <= '0;
            best_prio_reg   <= '0;
            best_id_reg     <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= pas_pkg::ST_OK;
            chosen_id_reg   <= '0;
            chosen_prio_reg <= '0;
            ready_count_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                step_reg <= aging_amount;
            end
            // an input beat always reloads the result flag below
            if (out_valid_reg && out_ready && !in_fire)
            begin
                out_valid_reg <= 1'b0;
            end

            rd_vld_reg <= ram_re;
            if (ram_re)
            begin
                rd_idx_reg <= ptr_reg[pas_pkg::IDX_BITS-1:0];
                ptr_reg    <= ptr_reg + pas_pkg::CNT_BITS'(1);
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        chosen_id_reg   <= '0;
                        chosen_prio_reg <= '0;
                        if (func == pas_pkg::FUNC_INSERT)
                        begin
                            out_valid_reg <= 1'b1;
                            if (full)
                            begin
                                status_reg      <= pas_pkg::ST_FULL;
                                ready_count_reg <= 5'(fill_reg);
                            end
                            else
                            begin
                                status_reg      <= pas_pkg::ST_OK;
                                ready_count_reg <= 5'(fill_reg + pas_pkg::CNT_BITS'(1));
                                fill_reg        <= fill_reg + pas_pkg::CNT_BITS'(1);
                            end
                        end
                        else if (fill_reg == '0)
                        begin
                            out_valid_reg   <= 1'b1;
                            status_reg      <= pas_pkg::ST_EMPTY;
                            ready_count_reg <= '0;
                        end
                        else
                        begin
                            out_valid_reg <= 1'b0;
                            ptr_reg       <= '0;
                            state_reg     <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (rd_vld_reg && take)
                    begin
                        best_idx_reg  <= rd_idx_reg;
                        best_prio_reg <= rd_prio;
                        best_id_reg   <= rd_id;
                    end
                    if (scan_last)
                    begin
                        if (fill_reg == pas_pkg::CNT_BITS'(1))
                        begin
                            // single entry: nothing left to compact or age
                            out_valid_reg   <= 1'b1;
                            status_reg      <= pas_pkg::ST_OK;
                            chosen_id_reg   <= 8'(rd_id);
                            chosen_prio_reg <= rd_prio;
                            ready_count_reg <= '0;
                            fill_reg        <= '0;
                            state_reg       <= S_IDLE;
                        end
                        else
                        begin
                            ptr_reg   <= '0;
                            state_reg <= S_COMPACT;
                        end
                    end
                end
                S_COMPACT:
                begin
                    if (compact_last)
                    begin
                        out_valid_reg   <= 1'b1;
                        status_reg      <= pas_pkg::ST_OK;
                        chosen_id_reg   <= 8'(best_id_reg);
                        chosen_prio_reg <= best_prio_reg;
                        ready_count_reg <= 5'(fill_m1);
                        fill_reg        <= fill_m1;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= pas_pkg::CNT_BITS'(pas_pkg::SLOTS))
        else $error("fill count above table size");

    a_empty_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && func == pas_pkg::FUNC_DISPATCH && fill_reg == '0)
        |=> (out_valid_reg && status_reg == pas_pkg::ST_EMPTY && state_reg == S_IDLE))
        else $error("empty dispatch did not report at once");

    a_compact_wr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMPACT && ram_we) |-> ({1'b0, ram_waddr} < fill_m1))
        else $error("compaction write past the shrunk table");

    a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !out_valid_reg)
        else $error("result pending while a dispatch is in flight");

endmodule

`default_nettype wire

/* sim/ready_table_checker.sv */
import pas_pkg::*;

module ready_table_checker (
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              func,
    input  logic [7:0]        task_id,
    input  logic signed [5:0] start_prio,

    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [1:0]        status,
    input  logic [7:0]        chosen_id,
    input  logic signed [5:0] chosen_prio,
    input  logic [4:0]        ready_count,

    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic signed [5:0] aging_amount,

    output int                mismatches,
    output int                results_seen,
    output int                expected_left,
    output int                full_inserts,
    output int                empty_dispatches,
    output int                tasks_served
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t           status;
        logic [7:0]        id;
        logic signed [5:0] prio;
        logic [4:0]        count;
    } sched_result_t;

    // shadow copy of the ready table, oldest entry at index 0
    logic [7:0]        slot_id   [SLOTS];
    logic signed [5:0] slot_prio [SLOTS];
    int                table_fill;
    logic signed [5:0] age_step;

    sched_result_t     expected_beats [$];
    sched_result_t     want;
    sched_result_t     got;
    int                bad;

    function automatic sched_result_t schedule_item(input logic f, input logic [7:0] id,
                                                    input logic signed [5:0] sp);
        sched_result_t r;
        int            p;
        int            best;
        int            aged;
        r.status = ST_OK;
        r.id     = '0;
        r.prio   = '0;
        if (f == FUNC_INSERT) begin
            if (table_fill >= SLOTS) begin
                r.status = ST_FULL;
            end
            else begin
                p = sp;
                if (p < PRIO_MIN)
                    p = PRIO_MIN;
                else if (p > PRIO_MAX)
                    p = PRIO_MAX;
                slot_id[table_fill]   = id;
                slot_prio[table_fill] = p[5:0];
                table_fill++;
            end
        end
        else if (table_fill == 0) begin
            r.status = ST_EMPTY;
        end
        else begin
            // strict less-than keeps the oldest entry on ties
            best = 0;
            for (int i = 1; i < table_fill; i++)
                if (slot_prio[i] < slot_prio[best])
                    best = i;
            r.id   = slot_id[best];
            r.prio = slot_prio[best];
            for (int i = best; i < table_fill - 1; i++) begin
                slot_id[i]   = slot_id[i + 1];
                slot_prio[i] = slot_prio[i + 1];
            end
            table_fill--;
            // an entry only ages when the result stays inside -20..+20
            for (int i = 0; i < table_fill; i++) begin
                aged = int'(slot_prio[i]) + int'(age_step);
                if (aged >= PRIO_MIN && aged <= PRIO_MAX)
                    slot_prio[i] = aged[5:0];
            end
        end
        r.count = table_fill[4:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            table_fill = 0;
            age_step   = AGE_RESET;
            expected_beats.delete();
            mismatches       <= 0;
            results_seen     <= 0;
            expected_left    <= 0;
            full_inserts     <= 0;
            empty_dispatches <= 0;
            tasks_served     <= 0;
        end
        else begin
            bad = 0;
            if (out_valid && out_ready) begin
                if (expected_beats.size() == 0) begin
                    $error("result beat with nothing expected: status %0d id %0d prio %0d count %0d",
                           status, chosen_id, chosen_prio, ready_count);
                    bad++;
                end
                else begin
                    want = expected_beats.pop_front();
                    if (status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        bad++;
                    end
                    if (chosen_id !== want.id) begin
                        $error("chosen_id: expected %0d, got %0d", want.id, chosen_id);
                        bad++;
                    end
                    if (chosen_prio !== want.prio) begin
                        $error("chosen_prio: expected %0d, got %0d", want.prio, chosen_prio);
                        bad++;
                    end
                    if (ready_count !== want.count) begin
                        $error("ready_count: expected %0d, got %0d", want.count, ready_count);
                        bad++;
                    end
                end
            end

            if (cfg_valid && cfg_ready)
                age_step = aging_amount;

            if (in_valid && in_ready) begin
                got = schedule_item(func, task_id, start_prio);
                expected_beats.push_back(got);
                if (got.status == ST_FULL)
                    full_inserts <= full_inserts + 1;
                if (got.status == ST_EMPTY)
                    empty_dispatches <= empty_dispatches + 1;
                if (got.status == ST_OK && func == FUNC_DISPATCH)
                    tasks_served <= tasks_served + 1;
            end

            mismatches    <= mismatches + bad;
            results_seen  <= results_seen + int'(out_valid && out_ready);
            expected_left <= expected_beats.size();
        end
    end

endmodule

/* sim/tb_priority_aging_scheduler_unit.sv */
import pas_pkg::*;

module tb_priority_aging_scheduler_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              func         = FUNC_INSERT;
    logic [7:0]        task_id      = '0;
    logic signed [5:0] start_prio   = '0;
    logic              out_ready    = 1'b0;
    logic              cfg_valid    = 1'b0;
    logic signed [5:0] aging_amount = AGE_RESET;

    logic              in_ready;
    logic              out_valid;
    logic [1:0]        status;
    logic [7:0]        chosen_id;
    logic signed [5:0] chosen_prio;
    logic [4:0]        ready_count;
    logic              cfg_ready;

    int mismatches;
    int results_seen;
    int expected_left;
    int full_inserts;
    int empty_dispatches;
    int tasks_served;

    int   beats_sent = 0;
    int   cycles     = 0;
    logic steady     = 1'b0;
    logic long_hold  = 1'b0;

    int   ready_left;
    int   hold_left;
    logic hold_seen;
    int   pick;

    always #10ns clk = ~clk;

    priority_aging_scheduler_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .task_id      (task_id),
        .start_prio   (start_prio),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .chosen_id    (chosen_id),
        .chosen_prio  (chosen_prio),
        .ready_count  (ready_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .aging_amount (aging_amount)
    );

    ready_table_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .func             (func),
        .task_id          (task_id),
        .start_prio       (start_prio),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .chosen_id        (chosen_id),
        .chosen_prio      (chosen_prio),
        .ready_count      (ready_count),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .aging_amount     (aging_amount),
        .mismatches       (mismatches),
        .results_seen     (results_seen),
        .expected_left    (expected_left),
        .full_inserts     (full_inserts),
        .empty_dispatches (empty_dispatches),
        .tasks_served     (tasks_served)
    );

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats sent, %0d results seen",
                     cycles, beats_sent, results_seen);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: random ready runs, plus one long hold-off so the block backs up
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            ready_left = 0;
            hold_left  = 0;
            hold_seen  = 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (long_hold && !hold_seen) begin
            hold_seen = 1'b1;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (ready_left > 0) begin
            ready_left--;
        end
        else begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                out_ready <= 1'b1;
                ready_left = $urandom_range(7);
            end
            else if (pick < 85) begin
                out_ready <= 1'b0;
                ready_left = $urandom_range(2);
            end
            else if (pick < 95) begin
                out_ready <= 1'b1;
                ready_left = $urandom_range(80, 20);
            end
            else begin
                out_ready <= 1'b0;
                ready_left = $urandom_range(40, 10);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(3, 1);
        else if (r < 95)
            return $urandom_range(10, 4);
        else
            return $urandom_range(50, 15);
    endfunction

    // valid stays up across back-to-back beats; it only drops for a gap or a settle
    task automatic offer(input logic f, input logic [7:0] id, input logic signed [5:0] p);
        int gap;
        in_valid   <= 1'b1;
        func       <= f;
        task_id    <= id;
        start_prio <= p;
        do @(posedge clk); while (!in_ready);
        beats_sent++;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (results_seen != beats_sent)
            @(posedge clk);
    endtask

    task automatic set_aging(input logic signed [5:0] step);
        settle();
        cfg_valid    <= 1'b1;
        aging_amount <= step;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic signed [5:0] age_plan [PHASES];
        logic signed [5:0] p;
        int                v;
        int                insert_weight;
        int                directed_items;

        age_plan = '{-6'sd2, -6'sd20, 6'sd0, 6'sd31, -6'sd32, -6'sd1,
                     6'sd5, -6'sd20, -6'sd7, 6'sd0, 6'sd20, -6'sd13};
        v = -int'($urandom_range(20));
        age_plan[PHASES-1] = v[5:0];

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset step of -1, empty dispatch, saturating inserts, ties, full table
        offer(FUNC_DISPATCH, 8'hFF, 6'sd31);
        offer(FUNC_INSERT, 8'h00, -6'sd32);
        offer(FUNC_INSERT, 8'hFF, 6'sd31);
        offer(FUNC_INSERT, 8'hA5, -6'sd20);
        offer(FUNC_INSERT, 8'h5A, 6'sd20);
        repeat (4)
            offer(FUNC_DISPATCH, 8'h00, -6'sd32);
        for (int i = 0; i < SLOTS; i++) begin
            v = (i % 4) * 5 - 10;
            offer(FUNC_INSERT, {i[3:0], ~i[3:0]}, v[5:0]);
        end
        offer(FUNC_INSERT, 8'h81, -6'sd20);
        directed_items = beats_sent;

        // random phases: drain, fill and balanced mixes under varied aging steps
        for (int ph = 0; ph < PHASES; ph++) begin
            steady = (ph == 4 || ph == 9);
            set_aging(age_plan[ph]);
            if (ph == 4)
                long_hold <= 1'b1;
            case (ph % 3)
                0:       insert_weight = 30;
                1:       insert_weight = 80;
                default: insert_weight = 55;
            endcase
            repeat (PHASE_ITEMS) begin
                v = $urandom_range(99);
                if (v < 85)
                    v = int'($urandom_range(40)) - 20;
                else if (v < 95)
                    v = int'($urandom_range(4)) - 2;
                else
                    v = int'($urandom_range(63));
                p = v[5:0];
                offer(($urandom_range(99) < insert_weight) ? FUNC_INSERT : FUNC_DISPATCH,
                      8'($urandom_range(255)), p);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d items (%0d directed) over %0d aging steps, including -32, 0 and +31.",
                 beats_sent, directed_items, PHASES);
        $display("Dispatched %0d tasks; %0d inserts hit a full table, %0d dispatches an empty one.",
                 tasks_served, full_inserts, empty_dispatches);
        if (mismatches == 0 && expected_left == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* priority_aging_scheduler_unit.f */
src/pas_pkg.sv
src/pas_ram.sv
src/priority_aging_scheduler_unit.sv
sim/ready_table_checker.sv
sim/tb_priority_aging_scheduler_unit.sv
